@@ src/gpr_pkg.sv @@
package gpr_pkg;

    // Sequencer states of the search engine.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_CHECK,
        ST_NREAD,
        ST_NEVAL,
        ST_POP,
        ST_POPW
    } state_t;

    // Neighbor directions, visited in this order.
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // Register indexes on the configuration port (byte address bit 2).
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Width used for comparing grid coordinates against sizes (sizes are at most 31).
    localparam int SIZE_CMP_W = 7;

endpackage

@@ src/grid_path_reachability_core.sv @@
// Grid path reachability core.
//
// Configuration: an APB-style port holds two registers, rows at byte address 0 and cols at
// byte address 4. A written value of 0 is stored as 1, and a value above the parameter
// maximum is stored as that maximum; a read returns the stored value. Any write restarts
// loading at the first cell. pready is always high.
//
// Input: one cell per beat in row-major order, taken at a rising edge with start high and
// busy low, one cell per cycle. The beat that carries the last cell of the grid starts a
// depth-first search from the top-left corner, and busy stays high until the search ends.
// Output: one result beat per loaded grid, path_found qualified by done for one cycle. The
// receiver cannot stall; busy drops in the cycle that done is shown.
//
// From the last cell to the result beat: the start cell is entered, then each cell gets a
// goal check and a visit of its neighbors in order, an out-of-range one skipped in ST_NREAD
// and an in-range one read there and judged in ST_NEVAL, as each memory has a single read
// port; the next cell comes from a stack pop (ST_POP, then ST_POPW). A found path stops at
// the goal's check. Visited marks are cleared as cells load, so no clearing pass is needed.
// Reset leaves rows and cols at 1 and the block in the load phase.
module grid_path_reachability_core
    import gpr_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cell_open,
    output logic        done,
    output logic        path_found,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int IDX_W    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SP_W     = IDX_W + 1;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [IDX_W-1:0] idx;
    } cell_pos_t;

    function automatic logic [4:0] clamp_size(input logic [4:0] v, input int max_size);
        logic [SIZE_CMP_W-1:0] m;
        m = SIZE_CMP_W'(max_size);
        if (v == 5'd0) begin
            return 5'd1;
        end
        if (SIZE_CMP_W'(v) > m) begin
            return m[4:0];
        end
        return v;
    endfunction

    // Memories.
    logic            grid_mem [CELL_CAP];
    logic            vis_mem  [CELL_CAP];
    cell_pos_t       stk_mem  [CELL_CAP];

    // Control registers.
    state_t          state_reg, state_next;
    logic [4:0]      rows_reg, rows_next;
    logic [4:0]      cols_reg, cols_next;
    logic [ROW_W-1:0] load_r_reg, load_r_next;
    logic [COL_W-1:0] load_c_reg, load_c_next;
    logic [IDX_W-1:0] load_idx_reg, load_idx_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    dir_t            dir_reg, dir_next;
    logic            done_reg, done_next;
    logic            found_reg, found_next;

    // Payload registers.
    cell_pos_t       cur_reg, cur_next;
    cell_pos_t       nb_reg, nb_next;
    logic            grid_rd_reg;
    logic            vis_rd_reg;
    cell_pos_t       stk_rd_reg;

    // Memory port controls.
    logic            grid_we;
    logic            vis_we;
    logic [IDX_W-1:0] vis_waddr;
    logic            vis_wdata;
    logic            stk_we;
    logic [IDX_W-1:0] stk_raddr;

    // Neighbor candidate.
    cell_pos_t       nb_cand;
    logic            nb_ok;

    logic            cfg_wr;
    logic            load_last;
    logic            at_goal;
    logic [SP_W-1:0] sp_dec;

    assign pready = 1'b1;
    assign busy   = (state_reg != ST_LOAD);
    assign done   = done_reg;
    assign path_found = found_reg;
    assign prdata = (paddr[2] == REG_COLS) ? {27'd0, cols_reg} : {27'd0, rows_reg};

    assign cfg_wr = psel & penable & pwrite & pready;
    assign sp_dec = sp_reg - SP_W'(1);

    assign load_last = (SIZE_CMP_W'(load_r_reg) == SIZE_CMP_W'(rows_reg) - SIZE_CMP_W'(1))
                    && (SIZE_CMP_W'(load_c_reg) == SIZE_CMP_W'(cols_reg) - SIZE_CMP_W'(1));
    assign at_goal   = (SIZE_CMP_W'(cur_reg.r) == SIZE_CMP_W'(rows_reg) - SIZE_CMP_W'(1))
                    && (SIZE_CMP_W'(cur_reg.c) == SIZE_CMP_W'(cols_reg) - SIZE_CMP_W'(1));

    // The neighbor in the current direction; indexes move by one row or one column.
    always_comb
    begin
        nb_cand = cur_reg;
        nb_ok   = 1'b0;
        unique case (dir_reg)
            DIR_UP:
            begin
                nb_ok       = (cur_reg.r != '0);
                nb_cand.r   = cur_reg.r - ROW_W'(1);
                nb_cand.idx = cur_reg.idx - IDX_W'(cols_reg);
            end
            DIR_DOWN:
            begin
                nb_ok       = (SIZE_CMP_W'(cur_reg.r) + SIZE_CMP_W'(1)) < SIZE_CMP_W'(rows_reg);
                nb_cand.r   = cur_reg.r + ROW_W'(1);
                nb_cand.idx = cur_reg.idx + IDX_W'(cols_reg);
            end
            DIR_LEFT:
            begin
                nb_ok       = (cur_reg.c != '0);
                nb_cand.c   = cur_reg.c - COL_W'(1);
                nb_cand.idx = cur_reg.idx - IDX_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok       = (SIZE_CMP_W'(cur_reg.c) + SIZE_CMP_W'(1)) < SIZE_CMP_W'(cols_reg);
                nb_cand.c   = cur_reg.c + COL_W'(1);
                nb_cand.idx = cur_reg.idx + IDX_W'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Sequencer: next state, register updates and memory port controls.
    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        load_r_next   = load_r_reg;
        load_c_next   = load_c_reg;
        load_idx_next = load_idx_reg;
        sp_next       = sp_reg;
        dir_next      = dir_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        cur_next      = cur_reg;
        nb_next       = nb_reg;
        grid_we       = 1'b0;
        vis_we        = 1'b0;
        vis_waddr     = load_idx_reg;
        vis_wdata     = 1'b0;
        stk_we        = 1'b0;
        stk_raddr     = sp_dec[IDX_W-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    // Store the cell and clear its visited mark for the coming search.
                    grid_we = 1'b1;
                    vis_we  = 1'b1;
                    if (load_last)
                    begin
                        load_r_next   = '0;
                        load_c_next   = '0;
                        load_idx_next = '0;
                        state_next    = ST_INIT;
                    end
                    else
                    begin
                        load_idx_next = load_idx_reg + IDX_W'(1);
                        if (SIZE_CMP_W'(load_c_reg) == SIZE_CMP_W'(cols_reg) - SIZE_CMP_W'(1))
                        begin
                            load_c_next = '0;
                            load_r_next = load_r_reg + ROW_W'(1);
                        end
                        else
                        begin
                            load_c_next = load_c_reg + COL_W'(1);
                        end
                    end
                end
            end
            ST_INIT:
            begin
                // The start cell counts as open and is entered without a stack trip.
                vis_we     = 1'b1;
                vis_waddr  = '0;
                vis_wdata  = 1'b1;
                cur_next   = '0;
                sp_next    = '0;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (at_goal)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    dir_next   = DIR_UP;
                    state_next = ST_NREAD;
                end
            end
            ST_NREAD:
            begin
                if (nb_ok)
                begin
                    nb_next    = nb_cand;
                    state_next = ST_NEVAL;
                end
                else if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NEVAL:
            begin
                if (grid_rd_reg && !vis_rd_reg)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = nb_reg.idx;
                    vis_wdata = 1'b1;
                    if (sp_reg < SP_W'(CELL_CAP))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                end
                if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_NREAD;
                end
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                cur_next   = stk_rd_reg;
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Register writes must come only while idle (not enforced); each restarts loading.
        if (cfg_wr)
        begin
            load_r_next   = '0;
            load_c_next   = '0;
            load_idx_next = '0;
            if (paddr[2] == REG_COLS)
            begin
                cols_next = clamp_size(pwdata[4:0], MAX_COLS);
            end
            else
            begin
                rows_next = clamp_size(pwdata[4:0], MAX_ROWS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            rows_reg     <= 5'd1;
            cols_reg     <= 5'd1;
            load_r_reg   <= '0;
            load_c_reg   <= '0;
            load_idx_reg <= '0;
            sp_reg       <= '0;
            dir_reg      <= DIR_UP;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            load_r_reg   <= load_r_next;
            load_c_reg   <= load_c_next;
            load_idx_reg <= load_idx_next;
            sp_reg       <= sp_next;
            dir_reg      <= dir_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        nb_reg  <= nb_next;
    end

    // Grid and visited memories share the neighbor read address.
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[load_idx_reg] <= cell_open;
        end
        grid_rd_reg <= grid_mem[nb_cand.idx];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[nb_cand.idx];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[sp_reg[IDX_W-1:0]] <= nb_reg;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

endmodule

@@ dv/grid_path_reachability_core_tb.sv @@
module grid_path_reachability_core_tb
    import gpr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Grid limits of the instance, and the sizes the checker works with.
    localparam int MAX_SIZE = 16;
    localparam int GRID_CAP = MAX_SIZE * MAX_SIZE;

    // Stimulus stops once about this many cell beats have been queued.
    localparam int TARGET_CELLS = 650;

    // Quiet cycles allowed after the last expected result before the size registers are
    // touched. busy drops with done, so no search activity trails the last result.
    localparam int SETTLE_CYCLES = 16;

    // One pending cell beat: its value and how many idle cycles come before it.
    typedef struct packed {
        logic       is_open;
        logic [3:0] gap;
    } cell_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        cell_open = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        done;
    logic        path_found;
    logic [31:0] prdata;
    logic        pready;

    // Cell beats waiting to be driven, and the path_found values still owed by the block.
    cell_beat_t cell_queue[$];
    logic       found_due[$];

    // Shadow of the block: effective grid size, loaded cells, and load position.
    int                  size_rows = 1;
    int                  size_cols = 1;
    int                  cells_loaded = 0;
    bit [GRID_CAP-1:0]   grid_bits = '0;

    int   cells_queued = 0;
    int   mismatches = 0;
    logic beat_taken = 1'b0;
    int   gap_left = 0;
    bit   gap_armed = 1'b0;

    grid_path_reachability_core #(
        .MAX_ROWS(MAX_SIZE),
        .MAX_COLS(MAX_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cell_open(cell_open),
        .done(done),
        .path_found(path_found),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    // Only the first ten mismatches are printed; the rest are just counted.
    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Flood the grid from the top-left corner over open cells and report whether the
    // bottom-right corner is reached. The start cell counts as open whatever was loaded,
    // so a 1x1 grid always reaches its goal, and a wall on the goal makes it unreachable.
    function automatic logic corner_reachable();
        bit [GRID_CAP-1:0] seen;
        int                pend[$];
        int                cur;
        int                goal;
        int                r;
        int                c;
        int                nr;
        int                nc;
        int                nxt;
        dir_t              dir;
        goal = size_rows * size_cols - 1;
        seen = '0;
        seen[0] = 1'b1;
        pend.push_back(0);
        while (pend.size() > 0)
        begin
            cur = pend.pop_back();
            if (cur == goal)
            begin
                return 1'b1;
            end
            r = cur / size_cols;
            c = cur % size_cols;
            for (int k = 0; k < 4; k++)
            begin
                dir = dir_t'(k);
                nr = r;
                nc = c;
                case (dir)
                    DIR_UP:    nr = r - 1;
                    DIR_DOWN:  nr = r + 1;
                    DIR_LEFT:  nc = c - 1;
                    DIR_RIGHT: nc = c + 1;
                endcase
                if (nr < 0 || nr >= size_rows || nc < 0 || nc >= size_cols)
                begin
                    continue;
                end
                nxt = nr * size_cols + nc;
                if (!grid_bits[nxt] || seen[nxt])
                begin
                    continue;
                end
                seen[nxt] = 1'b1;
                pend.push_back(nxt);
            end
        end
        return 1'b0;
    endfunction

    // Write one size register over the APB-style port, then read it back. A write stores
    // the low five bits, with 0 raised to 1 and anything above the maximum cut to it, and
    // it restarts loading at the first cell.
    task automatic write_size(input logic reg_idx, input int raw);
        int stored;
        stored = raw & 31;
        if (stored < 1)
        begin
            stored = 1;
        end
        if (stored > MAX_SIZE)
        begin
            stored = MAX_SIZE;
        end
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= 32'(raw);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_idx == REG_ROWS)
        begin
            size_rows = stored;
        end
        else
        begin
            size_cols = stored;
        end
        cells_loaded = 0;
        // Read back in the very next transfer; psel stays high across the two.
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(stored))
        begin
            log_mismatch($sformatf("register at 0x%0h read back: expected %0d, got %0d",
                                   {reg_idx, 2'b00}, stored, prdata));
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Queue cell beats taken from a bit vector, cell 0 first. The gap style picks no
    // idling, a random idle gap on every beat, or one on about one beat in four.
    task automatic push_cells(input bit [GRID_CAP-1:0] bits, input int count,
                              input int gap_style);
        cell_beat_t beat;
        for (int i = 0; i < count; i++)
        begin
            beat.is_open = bits[i];
            case (gap_style)
                0: beat.gap = 4'd0;
                1: beat.gap = 4'($urandom_range(0, 9));
                default: beat.gap = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 9)) : 4'd0;
            endcase
            cell_queue.push_back(beat);
        end
        cells_queued += count;
    endtask

    // Build a random grid at the current size. With carve set, a monotone walk of open
    // cells is forced from corner to corner so that found results are common. A count
    // below the grid size leaves the load unfinished, to be cut off by the next write.
    task automatic push_random_grid(input int open_pct, input bit carve, input int count,
                                    input int gap_style);
        bit [GRID_CAP-1:0] bits;
        int                r;
        int                c;
        bits = '0;
        for (int i = 0; i < size_rows * size_cols; i++)
        begin
            bits[i] = ($urandom_range(1, 100) <= open_pct);
        end
        if (carve)
        begin
            r = 0;
            c = 0;
            bits[0] = 1'b1;
            while (r < size_rows - 1 || c < size_cols - 1)
            begin
                if (r == size_rows - 1)
                begin
                    c++;
                end
                else if (c == size_cols - 1)
                begin
                    r++;
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    c++;
                end
                else
                begin
                    r++;
                end
                bits[r * size_cols + c] = 1'b1;
            end
        end
        push_cells(bits, count, gap_style);
    endtask

    // Let every queued beat go in and every owed result come out, then let the block
    // settle so that the size registers can be written safely.
    task automatic drain();
        while (cell_queue.size() > 0 || start)
        begin
            @(posedge clk);
        end
        while (found_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: works at the falling edge. A beat that is offered stays on the port until it
    // has been taken; after that the next one goes out once its idle gap has run down.
    // start is assigned at most once per falling edge, so back-to-back beats keep it high.
    always @(negedge clk)
    begin : cell_driver
        logic launch;
        launch = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || beat_taken)
        begin
            if (cell_queue.size() > 0)
            begin
                if (!gap_armed)
                begin
                    gap_left = cell_queue[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left == 0)
                begin
                    launch = 1'b1;
                    cell_open <= cell_queue[0].is_open;
                    cell_queue.pop_front();
                    gap_armed = 1'b0;
                end
                else
                begin
                    gap_left--;
                end
            end
            start <= launch;
        end
    end

    // Monitor: works at the rising edge. A result beat is checked before the cell beat of
    // the same edge is taken in, since a one-cell grid can be accepted at the very edge
    // where the previous grid's result is shown. Each accepted cell goes into the shadow
    // grid, and the last cell of a grid queues the flag that the block owes for it.
    always @(posedge clk)
    begin : result_monitor
        logic want;
        if (rst_n)
        begin
            if (done)
            begin
                if (found_due.size() == 0)
                begin
                    log_mismatch($sformatf("path_found=%0b with no grid pending", path_found));
                end
                else
                begin
                    want = found_due.pop_front();
                    if (path_found !== want)
                    begin
                        log_mismatch($sformatf(
                            "path_found on a %0dx%0d grid: expected %0b, got %0b",
                            size_rows, size_cols, want, path_found));
                    end
                end
            end
            if (start && !busy)
            begin
                if (cells_loaded < GRID_CAP)
                begin
                    grid_bits[cells_loaded] = cell_open;
                end
                cells_loaded++;
                if (cells_loaded >= size_rows * size_cols)
                begin
                    cells_loaded = 0;
                    found_due.push_back(corner_reachable());
                end
            end
            beat_taken <= start && !busy;
        end
    end

    // Run limit: far above the slowest legal run.
    initial
    begin
        #1600000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int   raw_a;
        int   raw_b;
        int   total;
        int   grids;
        int   gap_style;
        logic first_reg;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the grid is 1x1: found whatever the single cell holds.
        push_cells(256'b10, 2, 0);
        drain();

        // 2x2 grids: all open, blocked by a diagonal of walls, a wall on the start cell
        // (ignored), and a wall on the goal. Two trailing cells leave a load unfinished.
        write_size(REG_ROWS, 2);
        write_size(REG_COLS, 2);
        push_cells(256'b1111, 4, 0);
        push_cells(256'b1001, 4, 1);
        push_cells(256'b1110, 4, 0);
        push_cells(256'b0111, 4, 2);
        push_cells(256'b11, 2, 0);
        drain();

        // Writing 0 gives one row, which also throws away the unfinished load.
        write_size(REG_ROWS, 0);
        write_size(REG_COLS, 3);
        push_cells(256'b101, 3, 1);
        push_cells(256'b111, 3, 0);
        drain();

        // The largest grid, once: 31 is cut to the maximum, 16 is the maximum itself.
        write_size(REG_ROWS, 31);
        write_size(REG_COLS, 16);
        push_random_grid(50, 1'b1, size_rows * size_cols, 2);
        drain();

        // Random phases. Most use grids of up to five by five; some stretch one side up to
        // the full raw range with the other side short. Each phase runs a few grids with a
        // single idling style, and now and then ends with an unfinished load.
        while (cells_queued < TARGET_CELLS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                raw_a = $urandom_range(0, 5);
                raw_b = $urandom_range(0, 5);
            end
            else
            begin
                raw_a = $urandom_range(0, 31);
                raw_b = $urandom_range(0, 3);
            end
            first_reg = ($urandom_range(0, 1) == 1) ? REG_ROWS : REG_COLS;
            write_size(first_reg, raw_a);
            write_size(!first_reg, raw_b);
            total = size_rows * size_cols;
            gap_style = $urandom_range(0, 2);
            grids = 40 / total;
            if (grids < 1)
            begin
                grids = 1;
            end
            if (grids > 8)
            begin
                grids = 8;
            end
            repeat (grids)
            begin
                push_random_grid(25 * $urandom_range(1, 4), 1'($urandom_range(0, 1)), total,
                                 gap_style);
            end
            if (total > 1 && $urandom_range(0, 4) == 0)
            begin
                push_random_grid(50, 1'b0, $urandom_range(1, total - 1), gap_style);
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ grid_path_reachability_core.f @@
src/gpr_pkg.sv
src/grid_path_reachability_core.sv
dv/grid_path_reachability_core_tb.sv
